>>> rtl/oes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One euro smoother package
// Widths, reset values, constants and the structs that pass between the
// sequencer, the core, the bit-serial multiplier and the bit-serial divider.
// ----------------------------------------------------------------------------
package oes_pkg;

   localparam int VAL_W   = 24;  // Q8.16 sample and output
   localparam int RATE_W  = 40;  // Q24.16 derivative
   localparam int CFG_W   = 24;  // every register
   localparam int FC_W    = 32;  // Q16.16 cutoff
   localparam int ALPHA_W = 25;  // Q1.24 alpha, 0 to 1 inclusive
   localparam int SER_W   = 25;  // serial operand of the multiplier
   localparam int PAR_W   = 41;  // parallel operand of the multiplier
   localparam int PROD_W  = SER_W + PAR_W;
   localparam int STEP_W  = PROD_W - 24;
   localparam int NUM_W   = 49;  // dividend
   localparam int DEN_W   = 44;  // divisor
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [CFG_W-1:0] MIN_CUTOFF_RST  = 24'd65536;
   localparam logic [CFG_W-1:0] SPEED_COEFF_RST = 24'd459;
   localparam logic [CFG_W-1:0] DERIV_CUTOFF_RST = 24'd65536;
   localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 24'd559241;

   localparam logic [22:0]        TWO_PI_Q20 = 23'd6588397;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = {1'b1, {(ALPHA_W-1){1'b0}}};
   localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

   typedef struct packed {
      logic [CFG_W-1:0] min_cutoff;
      logic [CFG_W-1:0] speed_coefficient;
      logic [CFG_W-1:0] derivative_cutoff;
      logic [CFG_W-1:0] sample_period;
   } oes_cfg_type;

   typedef struct packed {
      logic                    start;
      logic [SER_W-1:0]        ser_op;
      logic signed [PAR_W-1:0] par_op;
   } oes_mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } oes_mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } oes_div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } oes_div_rsp_type;

   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] value;
   } oes_res_type;

endpackage

>>> rtl/oes_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one raw sample per transfer.
// ----------------------------------------------------------------------------
interface oes_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [oes_pkg::VAL_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

>>> rtl/oes_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed sample channel
// Valid/ready channel that carries one filtered sample per transfer.
// ----------------------------------------------------------------------------
interface oes_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [oes_pkg::VAL_W-1:0] smoothed_out;

   modport source (output valid, output smoothed_out, input ready);
   modport sink   (input valid, input smoothed_out, output ready);
endinterface

>>> rtl/oes_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Unsigned serial operand times signed parallel operand, one serial bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module oes_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  oes_pkg::oes_mul_req_type mul_req,
   output oes_pkg::oes_mul_rsp_type mul_rsp
);
   import oes_pkg::*;

   localparam int CNT_W = $clog2(SER_W + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SER_W-1:0]         ser_ff, ser_in;
   logic signed [PAR_W-1:0]  par_ff, par_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] addend;

   always_comb begin
      addend  = ser_ff[SER_W-1] ? PROD_W'(par_ff) : '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ser_in  = ser_ff;
      par_in  = par_ff;
      acc_in  = acc_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SER_W);
         ser_in  = mul_req.ser_op;
         par_in  = mul_req.par_op;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< 1) + addend;
         ser_in = ser_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_ff <= ser_in;
      par_ff <= par_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !busy_ff)
      else $error("multiplier started while busy");

endmodule

>>> rtl/oes_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle. The dividend register
// fills with quotient bits from the bottom as it shifts out at the top.
// ----------------------------------------------------------------------------
module oes_div (
   input  logic                     clock,
   input  logic                     reset,
   input  oes_pkg::oes_div_req_type div_req,
   output oes_pkg::oes_div_rsp_type div_rsp
);
   import oes_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      fits    = (rem_sh >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits the divisor width.
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

>>> rtl/oes_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One euro smoother sequencer
// Holds the filter state and steps one sample through derivative, alpha,
// blend and cutoff, issuing work to the shared serial multiplier and divider.
// ----------------------------------------------------------------------------
module oes_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  oes_pkg::oes_cfg_type             cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [oes_pkg::VAL_W-1:0] in_sample,
   input  logic                             out_free,
   output oes_pkg::oes_res_type             res,
   output oes_pkg::oes_mul_req_type         mul_req,
   input  oes_pkg::oes_mul_rsp_type         mul_rsp,
   output oes_pkg::oes_div_req_type         div_req,
   input  oes_pkg::oes_div_rsp_type         div_rsp
);
   import oes_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE_DIV,
      ST_ALPHA_LAUNCH,
      ST_T_MUL,
      ST_W_MUL,
      ST_ALPHA_DIV,
      ST_BLEND,
      ST_CUT_LAUNCH,
      ST_CUT_MUL,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic                    first_ff, first_in;
   logic                    value_pass_ff, value_pass_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic signed [VAL_W-1:0] last_ff, last_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic signed [RATE_W-1:0] dx_ff, dx_in;
   logic [CFG_W-1:0]        dt_ff, dt_in;
   logic [FC_W-1:0]         fc_ff, fc_in;
   oes_mul_req_type         mul_req_ff, mul_req_in;
   oes_div_req_type         div_req_ff, div_req_in;
   oes_res_type             res_ff, res_in;

   logic [CFG_W-1:0]         dt_sel;
   logic signed [VAL_W:0]    diff_val;
   logic [VAL_W:0]           diff_mag;
   logic [NUM_W-1:0]         quot;
   logic                     rate_over;
   logic [56:0]              t_sum;
   logic [39:0]              t_val;
   logic [63:0]              w_sum;
   logic [42:0]              w_val;
   logic [DEN_W-1:0]         d_val;
   logic [ALPHA_W-1:0]       alpha;
   logic signed [PROD_W-1:0] b_sum;
   logic signed [STEP_W-1:0] step;
   logic signed [STEP_W-1:0] rate_sum;
   logic signed [STEP_W-1:0] last_sum;
   logic [RATE_W-1:0]        rate_mag;
   logic [64:0]              c_sum;
   logic [47:0]              c_val;
   logic [48:0]              fc_wide;

   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      // A zero period acts as the shortest one.
      dt_sel    = (cfg.sample_period == '0) ? CFG_W'(1) : cfg.sample_period;
      diff_val  = (VAL_W+1)'(in_sample) - (VAL_W+1)'(last_ff);
      diff_mag  = diff_val[VAL_W] ? (VAL_W+1)'(-diff_val) : (VAL_W+1)'(diff_val);
      quot      = div_rsp.quot;
      rate_over = |quot[NUM_W-1:RATE_W-1];
      t_sum     = {1'b0, mul_rsp.product[55:0]} + 57'd32768;
      t_val     = t_sum[55:16];
      w_sum     = {1'b0, mul_rsp.product[62:0]} + 64'd524288;
      w_val     = w_sum[62:20];
      d_val     = DEN_W'(ALPHA_ONE) + DEN_W'(w_val);
      alpha     = ALPHA_ONE - quot[ALPHA_W-1:0];
      b_sum     = mul_rsp.product + {{(PROD_W-24){1'b0}}, 24'h80_0000};
      step      = b_sum[PROD_W-1:24];
      rate_sum  = STEP_W'(rate_ff) + step;
      last_sum  = STEP_W'(last_ff) + step;
      rate_mag  = rate_ff[RATE_W-1] ? RATE_W'(-rate_ff) : RATE_W'(rate_ff);
      c_sum     = {1'b0, mul_rsp.product[63:0]} + 65'd32768;
      c_val     = c_sum[63:16];
      fc_wide   = {1'b0, c_val} + 49'(cfg.min_cutoff);

      state_in         = state_ff;
      first_in         = first_ff;
      value_pass_in    = value_pass_ff;
      neg_in           = neg_ff;
      x_in             = x_ff;
      last_in          = last_ff;
      rate_in          = rate_ff;
      dx_in            = dx_ff;
      dt_in            = dt_ff;
      fc_in            = fc_ff;
      mul_req_in       = mul_req_ff;
      mul_req_in.start = 1'b0;
      div_req_in       = div_req_ff;
      div_req_in.start = 1'b0;
      res_in           = res_ff;
      res_in.valid     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               x_in  = in_sample;
               dt_in = dt_sel;
               if (first_ff) begin
                  // The first sample passes through and seeds the state.
                  first_in = 1'b0;
                  last_in  = in_sample;
                  rate_in  = '0;
                  state_in = ST_FINISH;
               end else begin
                  neg_in           = diff_val[VAL_W];
                  // Low bits of |diff| * 2^24 are zero, so the rounding half
                  // of the period simply fills them.
                  div_req_in.start = 1'b1;
                  div_req_in.num   = {diff_mag, 1'b0, dt_sel[CFG_W-1:1]};
                  div_req_in.den   = DEN_W'(dt_sel);
                  state_in         = ST_RATE_DIV;
               end
            end
         end
         ST_RATE_DIV: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  dx_in = rate_over ? RATE_MIN : -$signed(quot[RATE_W-1:0]);
               end else begin
                  dx_in = rate_over ? RATE_MAX : $signed(quot[RATE_W-1:0]);
               end
               fc_in         = FC_W'(cfg.derivative_cutoff);
               value_pass_in = 1'b0;
               state_in      = ST_ALPHA_LAUNCH;
            end
         end
         ST_ALPHA_LAUNCH: begin
            mul_req_in.start  = 1'b1;
            mul_req_in.ser_op = SER_W'(dt_ff);
            mul_req_in.par_op = {{(PAR_W-FC_W){1'b0}}, fc_ff};
            state_in          = ST_T_MUL;
         end
         ST_T_MUL: begin
            if (mul_rsp.done) begin
               mul_req_in.start  = 1'b1;
               mul_req_in.ser_op = SER_W'(TWO_PI_Q20);
               mul_req_in.par_op = {1'b0, t_val};
               state_in          = ST_W_MUL;
            end
         end
         ST_W_MUL: begin
            if (mul_rsp.done) begin
               // Dividend is 2^48 plus half the divisor.
               div_req_in.start = 1'b1;
               div_req_in.num   = {1'b1, 5'b0, d_val[DEN_W-1:1]};
               div_req_in.den   = d_val;
               state_in         = ST_ALPHA_DIV;
            end
         end
         ST_ALPHA_DIV: begin
            if (div_rsp.done) begin
               mul_req_in.start  = 1'b1;
               mul_req_in.ser_op = alpha;
               if (value_pass_ff) begin
                  mul_req_in.par_op = PAR_W'(x_ff) - PAR_W'(last_ff);
               end else begin
                  mul_req_in.par_op = PAR_W'(dx_ff) - PAR_W'(rate_ff);
               end
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            // prev + round(alpha * (x - prev)) stays between x and prev,
            // so no saturation is needed here.
            if (mul_rsp.done) begin
               if (value_pass_ff) begin
                  last_in  = last_sum[VAL_W-1:0];
                  state_in = ST_FINISH;
               end else begin
                  rate_in  = rate_sum[RATE_W-1:0];
                  state_in = ST_CUT_LAUNCH;
               end
            end
         end
         ST_CUT_LAUNCH: begin
            mul_req_in.start  = 1'b1;
            mul_req_in.ser_op = SER_W'(cfg.speed_coefficient);
            mul_req_in.par_op = {1'b0, rate_mag};
            state_in          = ST_CUT_MUL;
         end
         ST_CUT_MUL: begin
            if (mul_rsp.done) begin
               fc_in         = (|fc_wide[48:FC_W]) ? '1 : fc_wide[FC_W-1:0];
               value_pass_in = 1'b1;
               state_in      = ST_ALPHA_LAUNCH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               res_in.valid = 1'b1;
               res_in.value = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_ff      <= 1'b1;
         value_pass_ff <= 1'b0;
         last_ff       <= '0;
         rate_ff       <= '0;
         mul_req_ff    <= '0;
         div_req_ff    <= '0;
         res_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         value_pass_ff <= value_pass_in;
         last_ff       <= last_in;
         rate_ff       <= rate_in;
         mul_req_ff    <= mul_req_in;
         div_req_ff    <= div_req_in;
         res_ff        <= res_in;
      end
      neg_ff <= neg_in;
      x_ff   <= x_in;
      dx_ff  <= dx_in;
      dt_ff  <= dt_in;
      fc_ff  <= fc_in;
   end

   assign mul_req = mul_req_ff;
   assign div_req = div_req_ff;
   assign res     = res_ff;

   a_one_unit_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(mul_req_ff.start && div_req_ff.start))
      else $error("multiplier and divider started together");

   a_result_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> $past(out_free))
      else $error("result issued while output register was held");

endmodule

>>> rtl/one_euro_adaptive_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One euro adaptive smoother
// Adaptive low-pass filter whose cutoff rises with the smoothed derivative.
// Holds the configuration registers and the output register.
//
//   Channel   Direction  Handshake              Payload
//   req_chan  in         valid/ready            sample_in, signed Q8.16
//   rsp_chan  out        valid/ready            smoothed_out, signed Q8.16
//   APB       in/out     psel/penable, pready=1 4 regs of 24 bits at 4*i
//
// The first sample after reset passes straight through to the result.
// Each later sample takes one serial divide for the derivative, then two
// alpha evaluations (two serial multiplies and a divide each), two blends
// and one cutoff multiply.
// Reset is synchronous and clears the filter to its first-sample state.
// A finished result waits in the output register while the next sample is
// accepted; a stalled output holds only the final hand-off of the next one.
// ----------------------------------------------------------------------------
module one_euro_adaptive_smoother_core (
   input  logic                        clock,
   input  logic                        reset,
   oes_req_if.sink                     req_chan,
   oes_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [oes_pkg::CSR_AW-1:0]  paddr,
   input  logic [oes_pkg::CSR_DW-1:0]  pwdata,
   output logic [oes_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import oes_pkg::*;

   typedef enum logic [1:0] {
      CSR_MIN_CUTOFF,
      CSR_SPEED_COEFF,
      CSR_DERIV_CUTOFF,
      CSR_SAMPLE_PERIOD
   } csr_index_type;

   logic [CFG_W-1:0] min_cutoff_ff, min_cutoff_in;
   logic [CFG_W-1:0] speed_coeff_ff, speed_coeff_in;
   logic [CFG_W-1:0] deriv_cutoff_ff, deriv_cutoff_in;
   logic [CFG_W-1:0] sample_period_ff, sample_period_in;
   logic             out_valid_ff, out_valid_in;
   logic signed [VAL_W-1:0] out_data_ff, out_data_in;

   csr_index_type    csr_index;
   logic             csr_write;
   logic [CFG_W-1:0] csr_read_val;
   logic             out_free;
   oes_cfg_type      cfg_bus;
   oes_res_type      res_bus;
   oes_mul_req_type  mul_req;
   oes_mul_rsp_type  mul_rsp;
   oes_div_req_type  div_req;
   oes_div_rsp_type  div_rsp;

   assign csr_index = csr_index_type'(paddr[CSR_AW-1:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      min_cutoff_in    = min_cutoff_ff;
      speed_coeff_in   = speed_coeff_ff;
      deriv_cutoff_in  = deriv_cutoff_ff;
      sample_period_in = sample_period_ff;
      case (csr_index)
         CSR_MIN_CUTOFF:    csr_read_val = min_cutoff_ff;
         CSR_SPEED_COEFF:   csr_read_val = speed_coeff_ff;
         CSR_DERIV_CUTOFF:  csr_read_val = deriv_cutoff_ff;
         CSR_SAMPLE_PERIOD: csr_read_val = sample_period_ff;
         default:           csr_read_val = '0;
      endcase
      if (csr_write) begin
         case (csr_index)
            CSR_MIN_CUTOFF:    min_cutoff_in    = pwdata[CFG_W-1:0];
            CSR_SPEED_COEFF:   speed_coeff_in   = pwdata[CFG_W-1:0];
            CSR_DERIV_CUTOFF:  deriv_cutoff_in  = pwdata[CFG_W-1:0];
            CSR_SAMPLE_PERIOD: sample_period_in = pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign prdata = {{(CSR_DW-CFG_W){1'b0}}, csr_read_val};

   assign cfg_bus.min_cutoff        = min_cutoff_ff;
   assign cfg_bus.speed_coefficient = speed_coeff_ff;
   assign cfg_bus.derivative_cutoff = deriv_cutoff_ff;
   assign cfg_bus.sample_period     = sample_period_ff;

   // The output register is free when empty or when its transfer completes now.
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (res_bus.valid) begin
         out_valid_in = 1'b1;
         out_data_in  = res_bus.value;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cutoff_ff    <= MIN_CUTOFF_RST;
         speed_coeff_ff   <= SPEED_COEFF_RST;
         deriv_cutoff_ff  <= DERIV_CUTOFF_RST;
         sample_period_ff <= SAMPLE_PERIOD_RST;
         out_valid_ff     <= 1'b0;
      end else begin
         min_cutoff_ff    <= min_cutoff_in;
         speed_coeff_ff   <= speed_coeff_in;
         deriv_cutoff_ff  <= deriv_cutoff_in;
         sample_period_ff <= sample_period_in;
         out_valid_ff     <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.smoothed_out = out_data_ff;

   oes_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_bus),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_sample (req_chan.sample_in),
      .out_free  (out_free),
      .res       (res_bus),
      .mul_req   (mul_req),
      .mul_rsp   (mul_rsp),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   oes_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   oes_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_bus.valid |-> !out_valid_ff)
      else $error("result written over an untaken output");

endmodule

>>> test/tb_one_euro_adaptive_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One euro adaptive smoother testbench
// Drives raw samples through the valid/ready sample channel and configures
// the filter over APB. It keeps a bit-exact fixed-point filter of its own and
// checks every smoothed sample in order. Directed items cover reset values,
// first-sample seeding, the field extremes, zero periods and cutoffs, very
// large cutoffs and output back-pressure. Random phases with random settings
// and random idling on both channels follow, then a phase without idling.
// ----------------------------------------------------------------------------
module tb_one_euro_adaptive_smoother_core;
   import oes_pkg::*;

   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam int     END_SETTLE  = 400;
   localparam int     LONG_HOLD   = 2500;

   typedef enum int {
      REG_MIN_CUTOFF    = 0,
      REG_SPEED_COEFF   = 1,
      REG_DERIV_CUTOFF  = 2,
      REG_SAMPLE_PERIOD = 3
   } reg_index_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   oes_req_if req_chan ();
   oes_rsp_if rsp_chan ();

   one_euro_adaptive_smoother_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // Filter state and settings as the block should hold them.
   bit                      awaiting_first = 1'b1;
   logic signed [VAL_W-1:0]  last_smoothed = '0;
   logic signed [RATE_W-1:0] smoothed_rate = '0;
   logic [CFG_W-1:0] cfg_min_cutoff    = MIN_CUTOFF_RST;
   logic [CFG_W-1:0] cfg_speed_coeff   = SPEED_COEFF_RST;
   logic [CFG_W-1:0] cfg_deriv_cutoff  = DERIV_CUTOFF_RST;
   logic [CFG_W-1:0] cfg_sample_period = SAMPLE_PERIOD_RST;

   logic signed [VAL_W-1:0] expected_smoothed [$];

   int     error_count = 0;
   longint cycle_count = 0;
   bit     sender_gaps = 1'b1;
   bit     receiver_stalls = 1'b1;
   int     long_hold_cycles = 0;

   function automatic logic [ALPHA_W-1:0] alpha_of_cutoff(input logic [FC_W-1:0] fc,
                                                          input logic [CFG_W-1:0] dt);
      logic [127:0] t;
      logic [127:0] w;
      logic [127:0] d;
      logic [127:0] q;
      t = 128'(fc);
      t = (t * dt + 128'd32768) >> 16;
      w = (t * TWO_PI_Q20 + 128'd524288) >> 20;
      d = 128'd16777216 + w;
      q = ((128'd1 << 48) + (d >> 1)) / d;
      return ALPHA_W'(128'd16777216 - q);
   endfunction

   // alpha*x + (1-alpha)*prev with alpha in Q1.24, halves rounded upward.
   function automatic logic signed [63:0] blend_q24(input logic signed [63:0] x,
                                                    input logic signed [63:0] prev,
                                                    input logic [ALPHA_W-1:0] a);
      logic signed [127:0] wa;
      logic signed [127:0] sum;
      wa = $signed({103'd0, a});
      sum = wa * x + (128'sd16777216 - wa) * prev;
      return 64'((sum + 128'sd8388608) >>> 24);
   endfunction

   function automatic logic signed [VAL_W-1:0] predict_smoothed(
         input logic signed [VAL_W-1:0] x);
      logic [CFG_W-1:0]   dt;
      logic signed [63:0] diff;
      logic signed [63:0] dx;
      logic signed [63:0] r;
      logic signed [63:0] y;
      logic [127:0]       mag;
      logic [127:0]       q;
      logic [127:0]       rmag;
      logic [127:0]       fc;
      dt = (cfg_sample_period == '0) ? CFG_W'(1) : cfg_sample_period;
      if (awaiting_first) begin
         awaiting_first = 1'b0;
         last_smoothed = x;
         smoothed_rate = '0;
         return x;
      end
      diff = 64'(x);
      diff = diff - 64'(last_smoothed);
      mag = 128'((diff < 0) ? -diff : diff);
      q = ((mag << 24) + (dt >> 1)) / dt;
      if (q > 128'd549755813887) begin
         if (diff < 0) dx = 64'(RATE_MIN);
         else dx = 64'(RATE_MAX);
      end else begin
         dx = $signed(q[63:0]);
         if (diff < 0) dx = -dx;
      end
      r = blend_q24(dx, 64'(smoothed_rate),
                    alpha_of_cutoff(FC_W'(cfg_deriv_cutoff), dt));
      if (r > RATE_MAX) r = 64'(RATE_MAX);
      else if (r < RATE_MIN) r = 64'(RATE_MIN);
      smoothed_rate = r[RATE_W-1:0];
      rmag = 128'((r < 0) ? -r : r);
      fc = cfg_min_cutoff + ((cfg_speed_coeff * rmag + 128'd32768) >> 16);
      if (fc > 128'hFFFF_FFFF) fc = 128'hFFFF_FFFF;
      y = blend_q24(64'(x), 64'(last_smoothed), alpha_of_cutoff(fc[FC_W-1:0], dt));
      if (y > 64'sd8388607) y = 64'sd8388607;
      else if (y < -64'sd8388608) y = -64'sd8388608;
      last_smoothed = y[VAL_W-1:0];
      return y[VAL_W-1:0];
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("one_euro_adaptive_smoother_core test failed");
         $finish;
      end
   end

   // Result checker: every transfer on the result channel takes the oldest
   // expected sample.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_smoothed.size() == 0) begin
            error_count++;
            $display("%0t: unexpected smoothed_out: expected none, actual %0d",
                     $time, rsp_chan.smoothed_out);
         end else begin
            if (rsp_chan.smoothed_out !== expected_smoothed[0]) begin
               error_count++;
               $display("%0t: smoothed_out mismatch: expected %0d, actual %0d",
                        $time, expected_smoothed[0], rsp_chan.smoothed_out);
            end
            void'(expected_smoothed.pop_front());
         end
      end
   end

   // Receiver: random stall bursts, and a long hold when a test asks for one.
   initial begin : receiver
      int hold;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles > 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input logic signed [VAL_W-1:0] value);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample_in <= value;
      do @(posedge clock); while (!req_chan.ready);
      expected_smoothed.push_back(predict_smoothed(value));
   endtask

   // Stops offering samples and waits until every expected sample has come.
   // A sample is always still expected right after a transfer, so the loop
   // body runs whenever valid has been left high.
   task automatic wait_all_results();
      while (expected_smoothed.size() != 0) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic csr_read(input reg_index_type idx, input logic [CFG_W-1:0] expected);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_AW'(int'(idx) * 4);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DW'(expected)) begin
         error_count++;
         $display("%0t: register %s readback: expected %0d, actual %0d",
                  $time, idx.name(), expected, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(int'(idx) * 4);
      pwdata  <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_MIN_CUTOFF:    cfg_min_cutoff = value;
         REG_SPEED_COEFF:   cfg_speed_coeff = value;
         REG_DERIV_CUTOFF:  cfg_deriv_cutoff = value;
         REG_SAMPLE_PERIOD: cfg_sample_period = value;
      endcase
      @(posedge clock);
      csr_read(idx, value);
   endtask

   task automatic test_register_reset_values();
      csr_read(REG_MIN_CUTOFF, MIN_CUTOFF_RST);
      csr_read(REG_SPEED_COEFF, SPEED_COEFF_RST);
      csr_read(REG_DERIV_CUTOFF, DERIV_CUTOFF_RST);
      csr_read(REG_SAMPLE_PERIOD, SAMPLE_PERIOD_RST);
   endtask

   // The first sample seeds the filter; then full-scale swings at reset settings.
   task automatic test_first_sample_passthrough();
      send_sample(-24'sd8388608);
      send_sample(24'sd8388607);
      send_sample(24'sd0);
      send_sample(-24'sd1);
      send_sample(24'sd1);
   endtask

   // A zero period acts as the shortest one, so the raw derivative saturates.
   task automatic test_zero_sample_period();
      wait_all_results();
      csr_write(REG_SAMPLE_PERIOD, '0);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      send_sample(24'sd8388607);
   endtask

   // Zero cutoffs give an alpha of zero, so the filter holds its value.
   task automatic test_zero_cutoff();
      wait_all_results();
      csr_write(REG_SAMPLE_PERIOD, SAMPLE_PERIOD_RST);
      csr_write(REG_MIN_CUTOFF, '0);
      csr_write(REG_SPEED_COEFF, '0);
      csr_write(REG_DERIV_CUTOFF, '0);
      send_sample(24'sd4096000);
      send_sample(-24'sd8388608);
      send_sample(24'sd123456);
      wait_all_results();
      csr_write(REG_MIN_CUTOFF, MIN_CUTOFF_RST);
      csr_write(REG_SPEED_COEFF, SPEED_COEFF_RST);
      send_sample(24'sd8388607);
      send_sample(-24'sd65536);
   endtask

   task automatic test_large_cutoff();
      wait_all_results();
      csr_write(REG_MIN_CUTOFF, 24'hFF_FFFF);
      csr_write(REG_SPEED_COEFF, 24'hFF_FFFF);
      csr_write(REG_DERIV_CUTOFF, 24'hFF_FFFF);
      csr_write(REG_SAMPLE_PERIOD, 24'hFF_FFFF);
      send_sample(-24'sd8388608);
      send_sample(24'sd8388607);
      send_sample(24'sd0);
      send_sample(24'sd8388607);
   endtask

   // The receiver holds off long enough that the block fills and stalls its
   // input while samples keep being offered.
   task automatic test_output_backpressure();
      bit saved_gaps;
      wait_all_results();
      csr_write(REG_MIN_CUTOFF, MIN_CUTOFF_RST);
      csr_write(REG_SPEED_COEFF, SPEED_COEFF_RST);
      csr_write(REG_DERIV_CUTOFF, DERIV_CUTOFF_RST);
      csr_write(REG_SAMPLE_PERIOD, SAMPLE_PERIOD_RST);
      saved_gaps = sender_gaps;
      sender_gaps = 1'b0;
      long_hold_cycles = LONG_HOLD;
      repeat (6) send_sample($signed(VAL_W'($urandom)));
      wait_all_results();
      sender_gaps = saved_gaps;
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      int               trajectory;
      int               value;
      logic [CFG_W-1:0] setting;
      reg_index_type    idx;
      trajectory = $urandom_range(0, 200000) - 100000;
      for (int p = 0; p < phases; p++) begin
         wait_all_results();
         for (int r = 0; r < 4; r++) begin
            idx = reg_index_type'(r);
            case ($urandom_range(0, 5))
               0: setting = CFG_W'($urandom_range(1, 24'hFF_FFFF));
               1: setting = 24'hFF_FFFF;
               2: setting = CFG_W'($urandom_range(1, 255));
               3: setting = CFG_W'($urandom);
               default: begin
                  case (idx)
                     REG_MIN_CUTOFF:    setting = CFG_W'($urandom_range(16384, 524288));
                     REG_SPEED_COEFF:   setting = CFG_W'($urandom_range(0, 65536));
                     REG_DERIV_CUTOFF:  setting = CFG_W'($urandom_range(16384, 524288));
                     REG_SAMPLE_PERIOD: setting = CFG_W'($urandom_range(100000, 2000000));
                  endcase
               end
            endcase
            csr_write(idx, setting);
         end
         for (int i = 0; i < per_phase; i++) begin
            // Mostly a slowly moving signal with noise and some jumps, which
            // exercises the adaptive cutoff; the rest is full-range noise and extremes.
            case ($urandom_range(0, 9))
               0, 1: value = $signed(VAL_W'($urandom));
               2: value = $urandom_range(0, 1) ? 8388607 : -8388608;
               3: begin
                  trajectory = $urandom_range(0, 8000000) - 4000000;
                  value = trajectory;
               end
               default: begin
                  trajectory = trajectory + $urandom_range(0, 4000) - 2000;
                  if (trajectory > 8388607) trajectory = 8388607;
                  if (trajectory < -8388608) trajectory = -8388608;
                  value = trajectory + $urandom_range(0, 64) - 32;
                  if (value > 8388607) value = 8388607;
                  if (value < -8388608) value = -8388608;
               end
            endcase
            send_sample(VAL_W'(value));
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.sample_in <= '0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset_values();
      test_first_sample_passthrough();
      test_zero_sample_period();
      test_zero_cutoff();
      test_large_cutoff();
      test_output_backpressure();
      test_random_phases(6, 100);

      // Closing phase with both sides always ready.
      wait_all_results();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      test_random_phases(1, 80);

      wait_all_results();
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("one_euro_adaptive_smoother_core test passed");
      end else begin
         $display("one_euro_adaptive_smoother_core test failed");
      end
      $finish;
   end

endmodule
